/* design/linear_probe_hash_map_assert.svh */
// Assertion macros for the linear probe hash map.
// Included by modules that carry assertions; depends on nothing.
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LPHM_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lphm assertion failed");

// next-cycle implication
`define LPHM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lphm assertion failed");

`else

`define LPHM_ASSERT_IMPLY(label, clk, rst, pre, post)
`define LPHM_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* design/lphm_pkg.sv */
// Shared types and constants of the linear probe hash map.
// No dependencies.
package lphm_pkg;

   localparam int unsigned AddrBits   = 32;
   localparam int unsigned HandleBits = 16;

   // multiplicative hash constant (close to 2^32 divided by the golden ratio)
   localparam logic [AddrBits-1:0] HashMult = 32'd2654435761;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_INSERT = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_UPDATED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      func_type                func;
      logic [AddrBits-1:0]     addr;
      logic [HandleBits-1:0]   handle;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [HandleBits-1:0]   result_handle;
      status_type              status;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [AddrBits-1:0]     key;
      logic [HandleBits-1:0]   value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage

/* design/lphm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lphm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/linear_probe_hash_map.sv */
// Linear probe hash map: maps 32-bit addresses to 16-bit handles in an
// open-addressed table of SLOTS entries (SLOTS a power of two). After reset the
// block runs a clearing pass, one slot per cycle, and holds req_stall high
// until it is done. A transaction then latches the request, registers the hash
// multiply, waits on the slot memory's registered read, and then does one
// compare per probed slot on the single memory read port. The home slot is the
// low index bits of (addr >> 2) * 2654435761. A lookup stops at a matching key
// (hit), an empty slot (miss) or after every slot has been probed. An insert
// updates a matching key or fills the first empty slot, and a new key that
// would push occupancy above three quarters of SLOTS is rejected with status
// full. One transaction is in flight at a time; its result is held in an
// output register, so a new request is taken while the previous result still
// waits for the consumer.
// Depends on lphm_pkg, lphm_ram and linear_probe_hash_map_assert.svh.
`include "linear_probe_hash_map_assert.svh"

module linear_probe_hash_map #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  lphm_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lphm_pkg::rsp_type rsp_data
);

   import lphm_pkg::*;

   localparam int unsigned IdxW     = $clog2(SLOTS);
   localparam int unsigned CntW     = IdxW + 1;
   localparam int unsigned MaxCount = (SLOTS * 3) / 4;

   // sequencer and datapath registers
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [IdxW-1:0]   index_ff, index_in;
   logic [IdxW-1:0]   probe_ff, probe_in;
   logic [IdxW-1:0]   clear_ff, clear_in;
   logic [CntW-1:0]   occ_ff, occ_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // slot memory port
   logic              wr_en;
   logic [IdxW-1:0]   wr_addr;
   entry_type         wr_entry;
   logic [IdxW-1:0]   rd_addr;
   entry_type         rd_entry;

   // probe decode
   logic [AddrBits-1:0] hash_product;
   logic [IdxW-1:0]     index_next;
   logic                slot_empty;
   logic                slot_hit;
   logic                probe_last;
   logic                resolved;
   logic                out_free;
   logic                has_room;

   lphm_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // multiplicative hash, registered into index_ff in ST_HASH
   assign hash_product = {2'b00, req_ff.addr[AddrBits-1:2]} * HashMult;

   // wraps at SLOTS since SLOTS is a power of two
   assign index_next = IdxW'(index_ff + 1'b1);

   // rd_entry holds the slot at index_ff while in ST_CHECK
   assign slot_empty = !rd_entry.valid;
   assign slot_hit   = rd_entry.valid && (rd_entry.key == req_ff.addr);
   // every slot visited once: give up
   assign probe_last = (probe_ff == {IdxW{1'b1}});
   assign resolved   = slot_empty || slot_hit || probe_last;
   // output register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign has_room   = (occ_ff < CntW'(MaxCount));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_ff == {IdxW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH:  state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (resolved && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // datapath control
   always_comb begin
      req_in       = req_ff;
      index_in     = index_ff;
      probe_in     = probe_ff;
      clear_in     = clear_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = index_ff;
      wr_entry     = '0;
      rd_addr      = index_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep zero words through the slot memory
            wr_en    = 1'b1;
            wr_addr  = clear_ff;
            clear_in = IdxW'(clear_ff + 1'b1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ST_HASH: begin
            index_in = hash_product[IdxW-1:0];
            probe_in = '0;
         end
         ST_READ: begin
            // read of home slot issued at index_ff
         end
         ST_CHECK: begin
            if (!resolved) begin
               // move to next slot, read it now
               index_in = index_next;
               probe_in = IdxW'(probe_ff + 1'b1);
               rd_addr  = index_next;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = slot_hit;
               rsp_in.result_handle = '0;
               rsp_in.status        = STATUS_DONE;
               priority if (req_ff.func == FUNC_LOOKUP) begin
                  if (slot_hit) begin
                     rsp_in.result_handle = rd_entry.value;
                  end
               end else if (slot_hit) begin
                  rsp_in.status = STATUS_UPDATED;
                  wr_en         = 1'b1;
                  wr_entry      = '{valid: 1'b1, key: req_ff.addr, value: req_ff.handle};
               end else if (slot_empty && has_room) begin
                  wr_en    = 1'b1;
                  wr_entry = '{valid: 1'b1, key: req_ff.addr, value: req_ff.handle};
                  occ_in   = CntW'(occ_ff + 1'b1);
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      index_ff <= index_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never passes the three-quarter limit
   `LPHM_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= CntW'(MaxCount))
   // a finished probe always leaves a result in the output register
   `LPHM_ASSERT_NEXT(a_finish_result, clock, reset, (state_ff == ST_CHECK) && (state_in == ST_IDLE), rsp_valid_ff)
   // occupancy grows by one, and only with a slot write at the end of a probe
   `LPHM_ASSERT_IMPLY(a_occ_step, clock, reset, occ_in != occ_ff, (state_ff == ST_CHECK) && wr_en && (occ_in == CntW'(occ_ff + 1'b1)))

endmodule
